// ===== design/svpwm_pkg.sv =====
// ----------------------------------------------------------------------------
// svpwm_pkg
// Shared widths, constants and word types for the space vector pwm duty block.
// ----------------------------------------------------------------------------
package svpwm_pkg;

  // field widths
  localparam int VOLT_BITS = 16;
  localparam int DUTY_BITS = 16;

  // sqrt(3)/2 in q1.15 and the lowest bus value used as divisor (0.1 v)
  localparam int SQRT3_HALF_Q15 = 28378;
  localparam int BUS_MIN        = 26;

  // internal widths
  localparam int PHASE_BITS = VOLT_BITS + 16;              // phase voltage at 2^15 scale
  localparam int NUM_BITS   = VOLT_BITS + 18;              // 2*vx - (vmax + vmin)
  localparam int BIAS_BITS  = VOLT_BITS + DUTY_BITS + 17;  // bus * 2^16 * (1 + 2^D)
  localparam int SUM_BITS   = VOLT_BITS + DUTY_BITS + 20;  // full dividend before shift
  localparam int DIVD_BITS  = SUM_BITS - 17;               // dividend over bus
  localparam int REM_BITS   = VOLT_BITS + DUTY_BITS;       // remainder inside divider row
  localparam int LANES      = 3;

  // input word
  typedef struct packed {
    logic signed [VOLT_BITS-1:0] volt_alpha;
    logic signed [VOLT_BITS-1:0] volt_beta;
    logic        [VOLT_BITS-1:0] bus_voltage;
  } in_t;

  // result word
  typedef struct packed {
    logic [DUTY_BITS-1:0] phase_a_duty;
    logic [DUTY_BITS-1:0] phase_b_duty;
    logic [DUTY_BITS-1:0] phase_c_duty;
  } out_t;

  // word handed from cell to cell along the divider row
  typedef struct packed {
    logic [VOLT_BITS-1:0]                 bus;
    logic [LANES-1:0]                     sat;
    logic [LANES-1:0][REM_BITS-1:0]       rem;
    logic [LANES-1:0][DUTY_BITS-1:0]      quo;
  } div_word_t;

endpackage

// ===== design/svpwm_front.sv =====
// ----------------------------------------------------------------------------
// svpwm_front
// Inverse clarke, min/max common mode removal and dividend forming, four
// register stages, one word per cycle.
// ----------------------------------------------------------------------------
module svpwm_front
  import svpwm_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  in_t       in_word,
  output logic      out_valid,
  output div_word_t out_word
);

  localparam logic signed [15:0] K_Q15 = 16'(SQRT3_HALF_Q15);

  // stage a: phase voltages
  logic                              valid_a_r;
  logic signed [LANES-1:0][PHASE_BITS-1:0] volt_a_r;
  logic signed [LANES-1:0][PHASE_BITS-1:0] volt_a_nxt;
  logic        [VOLT_BITS-1:0]       bus_a_r;
  logic        [VOLT_BITS-1:0]       bus_a_nxt;

  // stage b: common mode removed, bus bias
  logic                              valid_b_r;
  logic        [LANES-1:0][NUM_BITS-1:0] num_b_r;
  logic        [LANES-1:0][NUM_BITS-1:0] num_b_nxt;
  logic        [BIAS_BITS-1:0]       bias_b_r;
  logic        [BIAS_BITS-1:0]       bias_b_nxt;
  logic        [VOLT_BITS-1:0]       bus_b_r;

  // stage c: dividend over bus
  logic                              valid_c_r;
  logic        [LANES-1:0][DIVD_BITS-1:0] divd_c_r;
  logic        [LANES-1:0][DIVD_BITS-1:0] divd_c_nxt;
  logic        [VOLT_BITS-1:0]       bus_c_r;

  // stage d: range check
  logic                              valid_d_r;
  div_word_t                         word_d_r;
  div_word_t                         word_d_nxt;

  // inverse clarke, bus floor
  always_comb begin
    logic signed [PHASE_BITS-1:0] alpha_x;
    logic signed [PHASE_BITS-1:0] beta_x;
    logic signed [PHASE_BITS-1:0] k_beta;
    logic signed [PHASE_BITS-1:0] half_alpha;
    alpha_x       = PHASE_BITS'(in_word.volt_alpha);
    beta_x        = PHASE_BITS'(in_word.volt_beta);
    k_beta        = beta_x * PHASE_BITS'(K_Q15);
    half_alpha    = alpha_x <<< 14;
    volt_a_nxt[0] = alpha_x <<< 15;
    volt_a_nxt[1] = k_beta - half_alpha;
    volt_a_nxt[2] = -k_beta - half_alpha;
    bus_a_nxt     = (in_word.bus_voltage < VOLT_BITS'(BUS_MIN)) ?
                    VOLT_BITS'(BUS_MIN) : in_word.bus_voltage;
  end

  // min/max common mode, rounding and centering bias
  always_comb begin
    logic signed [PHASE_BITS-1:0] vmax;
    logic signed [PHASE_BITS-1:0] vmin;
    logic signed [NUM_BITS-1:0]   cm_sum;
    logic signed [NUM_BITS-1:0]   twice;
    vmax = volt_a_r[0];
    vmin = volt_a_r[0];
    for (int i = 1; i < LANES; i++) begin
      if ($signed(volt_a_r[i]) > vmax) vmax = volt_a_r[i];
      if ($signed(volt_a_r[i]) < vmin) vmin = volt_a_r[i];
    end
    cm_sum = NUM_BITS'(vmax) + NUM_BITS'(vmin);
    for (int i = 0; i < LANES; i++) begin
      twice        = NUM_BITS'($signed(volt_a_r[i])) <<< 1;
      num_b_nxt[i] = twice - cm_sum;
    end
    bias_b_nxt = (BIAS_BITS'(bus_a_r) << 16) + (BIAS_BITS'(bus_a_r) << (16 + DUTY_BITS));
  end

  // scaled dividend, floor divided by 2^17
  always_comb begin
    logic signed [SUM_BITS-1:0] total;
    for (int i = 0; i < LANES; i++) begin
      total = (SUM_BITS'($signed(num_b_r[i])) <<< (DUTY_BITS + 1))
            + $signed(SUM_BITS'(bias_b_r));
      divd_c_nxt[i] = total[SUM_BITS-1:17];
    end
  end

  // clamp below zero, flag full scale, seed the divider row
  always_comb begin
    logic [DIVD_BITS-1:0] limit;
    logic                 hi;
    limit          = DIVD_BITS'(bus_c_r) << DUTY_BITS;
    word_d_nxt.bus = bus_c_r;
    for (int i = 0; i < LANES; i++) begin
      hi                = !divd_c_r[i][DIVD_BITS-1] && (divd_c_r[i] >= limit);
      word_d_nxt.sat[i] = hi;
      word_d_nxt.quo[i] = '0;
      if (divd_c_r[i][DIVD_BITS-1] || hi) begin
        word_d_nxt.rem[i] = '0;
      end else begin
        word_d_nxt.rem[i] = divd_c_r[i][REM_BITS-1:0];
      end
    end
  end

  // valid pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_a_r <= 1'b0;
      valid_b_r <= 1'b0;
      valid_c_r <= 1'b0;
      valid_d_r <= 1'b0;
    end else begin
      valid_a_r <= in_valid;
      valid_b_r <= valid_a_r;
      valid_c_r <= valid_b_r;
      valid_d_r <= valid_c_r;
    end
  end

  // data pipeline
  always_ff @(posedge clk) begin
    volt_a_r <= volt_a_nxt;
    bus_a_r  <= bus_a_nxt;
    num_b_r  <= num_b_nxt;
    bias_b_r <= bias_b_nxt;
    bus_b_r  <= bus_a_r;
    divd_c_r <= divd_c_nxt;
    bus_c_r  <= bus_b_r;
    word_d_r <= word_d_nxt;
  end

  assign out_valid = valid_d_r;
  assign out_word  = word_d_r;

endmodule

// ===== design/svpwm_div_cell.sv =====
// ----------------------------------------------------------------------------
// svpwm_div_cell
// One restoring divider cell: settles one quotient bit for all three phases
// and passes the word on to the next cell.
// ----------------------------------------------------------------------------
module svpwm_div_cell
  import svpwm_pkg::*;
#(
  parameter int SHIFT = 0
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  div_word_t in_word,
  output logic      out_valid,
  output div_word_t out_word
);

  logic      valid_r;
  div_word_t word_r;
  div_word_t word_nxt;

  // trial subtract of bus * 2^SHIFT per phase
  always_comb begin
    logic [REM_BITS-1:0] divisor;
    logic                ge;
    divisor      = REM_BITS'(in_word.bus) << SHIFT;
    word_nxt.bus = in_word.bus;
    word_nxt.sat = in_word.sat;
    for (int i = 0; i < LANES; i++) begin
      ge              = in_word.rem[i] >= divisor;
      word_nxt.rem[i] = ge ? (in_word.rem[i] - divisor) : in_word.rem[i];
      word_nxt.quo[i] = {in_word.quo[i][DUTY_BITS-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  assign out_valid = valid_r;
  assign out_word  = word_r;

endmodule

// ===== design/space_vector_pwm_duty.sv =====
// ----------------------------------------------------------------------------
// space_vector_pwm_duty
// Space vector pwm duty generator with min/max common mode injection.
//
//   channel   ports                        handshake
//   input     start, busy, in_word (in_t)  taken when start & !busy
//   result    out_valid, out_word (out_t)  one-cycle strobe, no back pressure
//
// A word can be taken every cycle; busy stays low. Each result passes
// through four front stages, one divider cell per duty bit and one output
// register. Most of the pipeline is the row of divider cells.
// Synchronous reset clears the valid bits only; words in flight are dropped.
// The receiver cannot stall, so nothing is ever held back.
// ----------------------------------------------------------------------------
module space_vector_pwm_duty
  import svpwm_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  in_t  in_word,
  output logic out_valid,
  output out_t out_word
);

  localparam int LATENCY = DUTY_BITS + 5;

  logic                     accept;
  logic      [DUTY_BITS:0]  row_valid;
  div_word_t [DUTY_BITS:0]  row_word;
  logic                     out_valid_r;
  out_t                     out_word_r;
  out_t                     out_word_nxt;
  logic [LANES-1:0][DUTY_BITS-1:0] duty;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // front stages
  svpwm_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (accept),
    .in_word   (in_word),
    .out_valid (row_valid[0]),
    .out_word  (row_word[0])
  );

  // divider row, most significant quotient bit first
  for (genvar k = 0; k < DUTY_BITS; k++) begin : g_cell
    svpwm_div_cell #(
      .SHIFT (DUTY_BITS - 1 - k)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (row_valid[k]),
      .in_word   (row_word[k]),
      .out_valid (row_valid[k+1]),
      .out_word  (row_word[k+1])
    );
  end

  // full scale saturation
  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      duty[i] = row_word[DUTY_BITS].sat[i] ? '1 : row_word[DUTY_BITS].quo[i];
    end
    out_word_nxt.phase_a_duty = duty[0];
    out_word_nxt.phase_b_duty = duty[1];
    out_word_nxt.phase_c_duty = duty[2];
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= row_valid[DUTY_BITS];
    end
  end

  always_ff @(posedge clk) begin
    out_word_r <= out_word_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // every accepted word comes out as a result after passing the whole pipeline
  a_word_out: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##LATENCY out_valid)
    else $error("accepted word did not produce a result");

  // no result without a matching word accepted at the pipeline input
  a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept, LATENCY))
    else $error("result without a matching accepted word");

  // a saturated phase a never carries a partial quotient into the row end
  a_sat_rem: assert property (@(posedge clk) disable iff (!rst_n)
    row_valid[DUTY_BITS] && row_word[DUTY_BITS].sat[0] |-> row_word[DUTY_BITS].quo[0] == '0)
    else $error("saturated phase a built a quotient");

endmodule
